[rtl/core/fbfa_pkg.sv]
// Shared types and codes for the fixed block free list allocator.
package fbfa_pkg;

  // Field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 32;

  // Block size after reset
  localparam logic [SIZE_W-1:0] BLOCK_WORDS_RST = 16'd1024;

  // Request operations
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic execute;  // run the stack access and counter updates
    logic publish;  // load the result into the output register
  } cmd_t;

endpackage

[rtl/core/fixed_block_free_list_allocator_top.sv]
// Top level of the fixed block free list allocator.
// Fixed-size block pool allocator: allocate pops the most recently freed handle
// from a last-in-first-out free stack (no size check), otherwise issues the next
// never-used handle if the request fits block_words; deallocate pushes a present
// handle; clear empties the stack and restarts handle issue but keeps the five
// saturating statistics counters reported with every result. Each transaction
// runs in three steps (capture, execute, publish) as the free stack lives in
// a single-port memory whose read data is registered before it reaches the
// output; one transaction is worked on at a time, and the next is accepted
// while the previous result still waits in the output register. A result that
// is stalled holds the block in its publish step. The stack memory needs no
// clearing after reset.
module fixed_block_free_list_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fbfa_pkg::SIZE_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [fbfa_pkg::FUNC_W-1:0]      func_i,
  input  logic [fbfa_pkg::SIZE_W-1:0]      req_size_i,
  input  logic [fbfa_pkg::HANDLE_W-1:0]    free_handle_i,
  input  logic                             handle_present_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [fbfa_pkg::STATUS_W-1:0]    status_o,
  output logic [fbfa_pkg::HANDLE_W-1:0]    out_handle_o,
  output logic [fbfa_pkg::COUNT_W-1:0]     alloc_count_o,
  output logic [fbfa_pkg::COUNT_W-1:0]     dealloc_count_o,
  output logic [fbfa_pkg::COUNT_W-1:0]     made_count_o,
  output logic [fbfa_pkg::COUNT_W-1:0]     freed_count_o,
  output logic [fbfa_pkg::COUNT_W-1:0]     reuse_count_o
);
  import fbfa_pkg::*;

  cmd_t cmd;

  // Sequencer
  fbfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Stack, counters and result register
  fbfa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .func_i           (func_i),
    .req_size_i       (req_size_i),
    .free_handle_i    (free_handle_i),
    .handle_present_i (handle_present_i),
    .status_o         (status_o),
    .out_handle_o     (out_handle_o),
    .alloc_count_o    (alloc_count_o),
    .dealloc_count_o  (dealloc_count_o),
    .made_count_o     (made_count_o),
    .freed_count_o    (freed_count_o),
    .reuse_count_o    (reuse_count_o)
  );

endmodule

[rtl/core/fbfa_ctrl.sv]
// Sequencer for the allocator: accept, execute, publish.
module fbfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fbfa_pkg::cmd_t cmd_o
);
  import fbfa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WB
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Output register can take a result when empty or draining this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // Derive commands from the current step
  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.execute = (state_q == ST_EXEC);
    cmd_o.publish = (state_q == ST_WB) && out_free;
  end

  // Next state and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and the registered valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // One transaction at a time: an accept is never followed by another at once
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("fbfa_ctrl: input accepted on consecutive cycles");

  // Execute always hands over to publish
  a_exec_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> (state_q == ST_WB))
    else $error("fbfa_ctrl: execute step not followed by publish");

  // A new result only appears after a publish step
  a_valid_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.publish))
    else $error("fbfa_ctrl: output valid raised without publish");
`endif

endmodule

[rtl/core/fbfa_dp.sv]
// Datapath for the allocator: free stack memory, pointers, counters, result register.
module fbfa_dp #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fbfa_pkg::cmd_t                   cmd_i,
  input  logic                             cfg_we_i,
  input  logic [fbfa_pkg::SIZE_W-1:0]      cfg_wdata_i,
  input  logic [fbfa_pkg::FUNC_W-1:0]      func_i,
  input  logic [fbfa_pkg::SIZE_W-1:0]      req_size_i,
  input  logic [fbfa_pkg::HANDLE_W-1:0]    free_handle_i,
  input  logic                             handle_present_i,
  output logic [fbfa_pkg::STATUS_W-1:0]    status_o,
  output logic [fbfa_pkg::HANDLE_W-1:0]    out_handle_o,
  output logic [fbfa_pkg::COUNT_W-1:0]     alloc_count_o,
  output logic [fbfa_pkg::COUNT_W-1:0]     dealloc_count_o,
  output logic [fbfa_pkg::COUNT_W-1:0]     made_count_o,
  output logic [fbfa_pkg::COUNT_W-1:0]     freed_count_o,
  output logic [fbfa_pkg::COUNT_W-1:0]     reuse_count_o
);
  import fbfa_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_W'(1);
  endfunction

  // Free stack storage
  logic [HANDLE_W-1:0] stack_mem [MAX_BLOCKS];
  logic [HANDLE_W-1:0] rd_data_q;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;

  // Captured transaction
  logic [FUNC_W-1:0]   func_q;
  logic [SIZE_W-1:0]   req_q;
  logic [HANDLE_W-1:0] fh_q;
  logic                pres_q;

  // Configuration
  logic [SIZE_W-1:0]   block_words_q;

  // Pool state and statistics
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [CNT_W-1:0]    next_q, next_d;
  logic [CNT_W-1:0]    fill_dec;
  logic [COUNT_W-1:0]  allocs_q, allocs_d;
  logic [COUNT_W-1:0]  deallocs_q, deallocs_d;
  logic [COUNT_W-1:0]  made_q, made_d;
  logic [COUNT_W-1:0]  freed_q, freed_d;
  logic [COUNT_W-1:0]  reused_q, reused_d;

  // Pending result between execute and publish
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic                res_pop_q, res_pop_d;

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      req_q  <= req_size_i;
      fh_q   <= free_handle_i;
      pres_q <= handle_present_i;
    end
  end

  // Hold the block size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_words_q <= BLOCK_WORDS_RST;
    end else if (cfg_we_i) begin
      block_words_q <= cfg_wdata_i;
    end
  end

  assign fill_dec = fill_q - CNT_W'(1);

  // Decide the operation outcome and next pool state
  always_comb begin
    fill_d       = fill_q;
    next_d       = next_q;
    allocs_d     = allocs_q;
    deallocs_d   = deallocs_q;
    made_d       = made_q;
    freed_d      = freed_q;
    reused_d     = reused_q;
    res_status_d = ST_IGNORED;
    res_handle_d = '0;
    res_pop_d    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = fill_q[ADDR_W-1:0];
    mem_raddr    = fill_dec[ADDR_W-1:0];
    case (func_q)
      FUNC_ALLOC: begin
        allocs_d = sat_inc(allocs_q);
        if (fill_q != '0) begin
          // Pop the most recent freed handle, size is not checked
          fill_d       = fill_dec;
          mem_re       = 1'b1;
          res_pop_d    = 1'b1;
          reused_d     = sat_inc(reused_q);
          res_status_d = ST_REUSED;
        end else if (req_q > block_words_q) begin
          res_status_d = ST_TOO_LARGE;
        end else if (next_q >= MAX_CNT) begin
          res_status_d = ST_EXHAUSTED;
        end else begin
          res_handle_d = HANDLE_W'(next_q);
          next_d       = next_q + CNT_W'(1);
          made_d       = sat_inc(made_q);
          res_status_d = ST_NEW;
        end
      end
      FUNC_FREE: begin
        // Push a present handle if the stack has room
        if (pres_q && (fill_q < MAX_CNT)) begin
          mem_we       = 1'b1;
          fill_d       = fill_q + CNT_W'(1);
          deallocs_d   = sat_inc(deallocs_q);
          freed_d      = sat_inc(freed_q);
          res_status_d = ST_FREED;
        end
      end
      FUNC_CLEAR: begin
        fill_d       = '0;
        next_d       = '0;
        res_status_d = ST_CLEARED;
      end
      default: begin
        res_status_d = ST_IGNORED;
      end
    endcase
  end

  // Stack memory with registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && mem_we) begin
      stack_mem[mem_waddr] <= fh_q;
    end
    if (cmd_i.execute && mem_re) begin
      rd_data_q <= stack_mem[mem_raddr];
    end
  end

  // Advance pool state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      next_q     <= '0;
      allocs_q   <= '0;
      deallocs_q <= '0;
      made_q     <= '0;
      freed_q    <= '0;
      reused_q   <= '0;
    end else if (cmd_i.execute) begin
      fill_q     <= fill_d;
      next_q     <= next_d;
      allocs_q   <= allocs_d;
      deallocs_q <= deallocs_d;
      made_q     <= made_d;
      freed_q    <= freed_d;
      reused_q   <= reused_d;
    end
  end

  // Hold the pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_status_q <= res_status_d;
      res_handle_q <= res_handle_d;
      res_pop_q    <= res_pop_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      status_o        <= res_status_q;
      out_handle_o    <= res_pop_q ? rd_data_q : res_handle_q;
      alloc_count_o   <= allocs_q;
      dealloc_count_o <= deallocs_q;
      made_count_o    <= made_q;
      freed_count_o   <= freed_q;
      reuse_count_o   <= reused_q;
    end
  end

`ifndef SYNTH
  // Stack fill never passes the pool size
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= MAX_CNT)
    else $error("fbfa_dp: stack fill above pool size");

  // Handle issue never passes the pool size
  a_next_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= MAX_CNT)
    else $error("fbfa_dp: new handle counter above pool size");

  // A pop only ever happens from a non-empty stack and shrinks it by one
  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && mem_re) |=> (fill_q == $past(fill_dec)) && res_pop_q)
    else $error("fbfa_dp: pop did not shrink the stack");
`endif

endmodule
